FILE: hw/rtl/sbgpf_pkg.sv
// Shared widths, limits, defaults and register codes of the spectrum bin group peak finder.
// Used by the top level and its port checker; depends on nothing else.
`timescale 1ns / 1ps

package sbgpf_pkg;

    // Default sample width of one bin component
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Frame limits
    localparam int MAX_BINS  = 2048;
    localparam int MAX_GROUP = 16;

    // Field and state widths
    localparam int GROUP_W    = 11;
    localparam int SUM_W      = 21;
    localparam int OUT_SUM_W  = 20;
    localparam int FREQ_W     = 22;
    localparam int GSIZE_W    = 5;
    localparam int SPACING_W  = 16;
    localparam int POS_W      = 4;
    localparam int GS_W       = GROUP_W + GSIZE_W;
    localparam int PROD_W     = GS_W + SPACING_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SPACING_W;

    // Saturation limits
    localparam logic [SUM_W-1:0]     SUM_MAX     = '1;
    localparam logic [OUT_SUM_W-1:0] OUT_SUM_MAX = '1;
    localparam logic [FREQ_W-1:0]    FREQ_MAX    = '1;
    localparam int GROUP_IDX_MAX_I = ((MAX_BINS - 1) < 2047) ? (MAX_BINS - 1) : 2047;
    localparam logic [GROUP_W-1:0]   GROUP_IDX_MAX = GROUP_W'(GROUP_IDX_MAX_I);

    // Register reset values
    localparam logic [GSIZE_W-1:0]   DEF_GROUP_SIZE  = GSIZE_W'(3);
    localparam logic [SPACING_W-1:0] DEF_BIN_SPACING = SPACING_W'(1);

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROUP_SIZE  = 1'b0,
        CFG_BIN_SPACING = 1'b1
    } t_cfg_idx;

endpackage

FILE: hw/rtl/spectrum_bin_group_peak_finder.sv
// Spectral peak finder over groups of FFT bins: bit-serial magnitude, group sums, peak report.
// Depends on sbgpf_pkg for widths, limits, defaults and register codes.
`timescale 1ns / 1ps

// Each accepted bin passes through S_IDLE, S_SQUARE, S_ROOT and S_ACCUM before the next one
// is taken: MSB-first shift-and-add in S_SQUARE forms re^2 + im^2, then the floor square
// root comes out one bit per cycle in S_ROOT, and S_ACCUM adds the magnitude into the group
// sum and updates the best group. The bin flagged last_bin goes on through S_FMUL and S_FSHIFT,
// which form the frequency (one group-by-size product, then 16 shift-and-add steps over
// bin_spacing_hz), and S_OUT loads the result register. A result waiting in that register
// does not hold up further bins; only the next frame's result waits for it to be taken.
// Groups are compared on undivided sums, a short final group counts, ties keep the earlier
// group, and the frequency saturates at its 22-bit maximum.
module spectrum_bin_group_peak_finder
    import sbgpf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data,
    // bin input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_im,
    input  logic                           i_last_bin,
    // peak result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [GROUP_W-1:0]             o_peak_group,
    output logic [OUT_SUM_W-1:0]           o_peak_sum,
    output logic [FREQ_W-1:0]              o_peak_frequency_hz
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int SQ_W  = 2 * SW;
    localparam int REM_W = SW + 2;
    localparam int ADD_W = ((SW > SUM_W) ? SW : SUM_W) + 1;
    localparam int CNT_W = ($clog2(SW) > $clog2(SPACING_W)) ? $clog2(SW) : $clog2(SPACING_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_ACCUM,
        S_FMUL,
        S_FSHIFT,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [GSIZE_W-1:0]   r_group_size;
    logic [SPACING_W-1:0] r_bin_spacing;

    // magnitude datapath
    logic [SW-1:0]    r_a, r_b;
    logic [SW-1:0]    r_a_bits, r_b_bits;
    logic [SQ_W-1:0]  r_sq;
    logic [REM_W-1:0] r_rem;
    logic [SW-1:0]    r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_last;

    // frame state
    logic [SUM_W-1:0]   r_group_sum;
    logic [POS_W-1:0]   r_pos;
    logic [GROUP_W-1:0] r_group_count;
    logic [SUM_W-1:0]   r_best_sum;
    logic [GROUP_W-1:0] r_best_group;

    // result staging
    logic [GROUP_W-1:0]   r_res_group;
    logic [SUM_W-1:0]     r_res_sum;
    logic [GSIZE_W-1:0]   r_res_size;
    logic [GS_W-1:0]      r_gs;
    logic [SPACING_W-1:0] r_sp_bits;
    logic [PROD_W-1:0]    r_prod;

    logic                 r_out_valid;

    // combinational helpers
    logic [SW-1:0]      re_u, im_u, abs_re, abs_im;
    logic [SQ_W-1:0]    add_a, add_b, n_sq;
    logic [REM_W-1:0]   rem_sh, trial;
    logic               root_bit;
    logic [GSIZE_W-1:0] eff_size;
    logic [ADD_W-1:0]   sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic [POS_W:0]     pos_inc;
    logic               close_grp;
    logic [SUM_W-1:0]   n_group_sum;
    logic [POS_W-1:0]   n_pos;
    logic [GROUP_W-1:0] n_group_count;
    logic [SUM_W-1:0]   n_best_sum;
    logic [GROUP_W-1:0] n_best_group;
    logic [PROD_W-1:0]  prod_add;
    logic               out_free;

    // Take absolute values of the incoming components
    assign re_u   = i_re;
    assign im_u   = i_im;
    assign abs_re = re_u[SW-1] ? (~re_u + 1'b1) : re_u;
    assign abs_im = im_u[SW-1] ? (~im_u + 1'b1) : im_u;

    // One shift-and-add step of re^2 + im^2, multiplier bits taken MSB first
    assign add_a = r_a_bits[SW-1] ? SQ_W'(r_a) : '0;
    assign add_b = r_b_bits[SW-1] ? SQ_W'(r_b) : '0;
    assign n_sq  = {r_sq[SQ_W-2:0], 1'b0} + add_a + add_b;

    // One restoring square-root step: bring down two radicand bits, try the next root bit
    assign rem_sh   = {r_rem[SW-1:0], r_sq[SQ_W-1:SQ_W-2]};
    assign trial    = {r_root, 2'b01};
    assign root_bit = (rem_sh >= trial);

    // Clamp the group size into its working range
    always_comb begin
        if (r_group_size == '0) begin
            eff_size = GSIZE_W'(1);
        end else if (int'(r_group_size) > MAX_GROUP) begin
            eff_size = GSIZE_W'(MAX_GROUP);
        end else begin
            eff_size = r_group_size;
        end
    end

    // Add the magnitude into the group, close the group and update the best one
    assign sum_wide  = ADD_W'(r_group_sum) + ADD_W'(r_root);
    assign sum_sat   = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign pos_inc   = {1'b0, r_pos} + 1'b1;
    assign close_grp = (pos_inc >= eff_size) || r_last;

    always_comb begin
        n_best_sum    = r_best_sum;
        n_best_group  = r_best_group;
        n_group_count = r_group_count;
        n_group_sum   = sum_sat;
        n_pos         = pos_inc[POS_W-1:0];
        if (close_grp) begin
            if (sum_sat > r_best_sum) begin
                n_best_sum   = sum_sat;
                n_best_group = r_group_count;
            end
            if (r_group_count < GROUP_IDX_MAX) begin
                n_group_count = r_group_count + 1'b1;
            end
            n_group_sum = '0;
            n_pos       = '0;
        end
    end

    // One shift-and-add step of the frequency product, spacing bits taken MSB first
    assign prod_add = r_sp_bits[SPACING_W-1] ? PROD_W'(r_gs) : '0;
    assign out_free = !r_out_valid || !i_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size  <= DEF_GROUP_SIZE;
            r_bin_spacing <= DEF_BIN_SPACING;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GROUP_SIZE:  r_group_size  <= i_cfg_data[GSIZE_W-1:0];
                CFG_BIN_SPACING: r_bin_spacing <= i_cfg_data[SPACING_W-1:0];
            endcase
        end
    end

    // Sequence one bin through square, root and accumulate; report on the last bin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_group_sum   <= '0;
            r_pos         <= '0;
            r_group_count <= '0;
            r_best_sum    <= '0;
            r_best_group  <= '0;
        end else begin
            // drop the result once the receiver has taken it; in S_OUT the load below decides
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_a      <= abs_re;
                        r_b      <= abs_im;
                        r_a_bits <= abs_re;
                        r_b_bits <= abs_im;
                        r_last   <= i_last_bin;
                        r_sq     <= '0;
                        r_cnt    <= CNT_W'(SW - 1);
                        r_state  <= S_SQUARE;
                    end
                end

                S_SQUARE: begin
                    r_sq     <= n_sq;
                    r_a_bits <= {r_a_bits[SW-2:0], 1'b0};
                    r_b_bits <= {r_b_bits[SW-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= CNT_W'(SW - 1);
                        r_state <= S_ROOT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end

                S_ROOT: begin
                    r_sq   <= {r_sq[SQ_W-3:0], 2'b00};
                    r_rem  <= root_bit ? (rem_sh - trial) : rem_sh;
                    r_root <= {r_root[SW-2:0], root_bit};
                    if (r_cnt == '0) begin
                        r_state <= S_ACCUM;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end

                S_ACCUM: begin
                    if (r_last) begin
                        // latch the frame's result and clear the frame
                        r_res_group   <= n_best_group;
                        r_res_sum     <= n_best_sum;
                        r_res_size    <= eff_size;
                        r_group_sum   <= '0;
                        r_pos         <= '0;
                        r_group_count <= '0;
                        r_best_sum    <= '0;
                        r_best_group  <= '0;
                        r_state       <= S_FMUL;
                    end else begin
                        r_group_sum   <= n_group_sum;
                        r_pos         <= n_pos;
                        r_group_count <= n_group_count;
                        r_best_sum    <= n_best_sum;
                        r_best_group  <= n_best_group;
                        r_state       <= S_IDLE;
                    end
                end

                S_FMUL: begin
                    r_gs      <= GS_W'(r_res_group) * GS_W'(r_res_size);
                    r_sp_bits <= r_bin_spacing;
                    r_prod    <= '0;
                    r_cnt     <= CNT_W'(SPACING_W - 1);
                    r_state   <= S_FSHIFT;
                end

                S_FSHIFT: begin
                    r_prod    <= {r_prod[PROD_W-2:0], 1'b0} + prod_add;
                    r_sp_bits <= {r_sp_bits[SPACING_W-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end

                S_OUT: begin
                    // hold until the result register is free
                    if (out_free) begin
                        r_out_valid         <= 1'b1;
                        o_peak_group        <= r_res_group;
                        o_peak_sum          <= (r_res_sum > SUM_W'(OUT_SUM_MAX)) ?
                                               OUT_SUM_MAX : r_res_sum[OUT_SUM_W-1:0];
                        o_peak_frequency_hz <= (r_prod > PROD_W'(FREQ_MAX)) ?
                                               FREQ_MAX : r_prod[FREQ_W-1:0];
                        r_state             <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

FILE: hw/rtl/sbgpf_checker.sv
// Port-level checks of the spectrum bin group peak finder, bound to its top level.
// Depends on sbgpf_pkg for field widths.
`timescale 1ns / 1ps

module sbgpf_checker
    import sbgpf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input logic [CFG_DATA_W-1:0]          i_cfg_data,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic signed [SAMPLE_WIDTH-1:0] i_re,
    input logic signed [SAMPLE_WIDTH-1:0] i_im,
    input logic                           i_last_bin,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [GROUP_W-1:0]             o_peak_group,
    input logic [OUT_SUM_W-1:0]           o_peak_sum,
    input logic [FREQ_W-1:0]              o_peak_frequency_hz
);

    // Leave reset idle, with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

    // A stalled result holds its fields
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_peak_group) && $stable(o_peak_sum)
            && $stable(o_peak_frequency_hz))
        else $error("stalled result changed");

    // An accepted bin keeps the input busy and cannot raise a result at once
    a_bin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall && !$rose(o_valid))
        else $error("input free or result raised right after a bin transaction");

    // Group zero lies at zero hertz
    a_group0_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_peak_group == '0) |-> (o_peak_frequency_hz == '0))
        else $error("nonzero frequency for group zero");

endmodule

bind spectrum_bin_group_peak_finder sbgpf_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sbgpf_checker (.*);
